FILE: sv/text_console_character_engine_assert.svh
// ----------------------------------------------------------------------------
// Text console character engine assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define TCCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TCCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Text console character engine package
// Screen geometry, field widths, character codes and sequencer types.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  // Screen geometry.
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;
  localparam int unsigned CELL_AW = $clog2(CELLS);

  // Field widths.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned CURSOR_W = 11;
  localparam int unsigned CELL_W   = 16;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned TAB_W    = 3;

  // Configuration port.
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_TEXT_COLOR = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_RESET    = 8'h07;

  // Derived limits.
  localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]   COL_LAST   = COL_W'(COLUMNS - 1);
  localparam logic [CELL_AW-1:0] COLS_A     = CELL_AW'(COLUMNS);
  localparam logic [CELL_AW-1:0] SCROLL_END = CELL_AW'(CELLS - COLUMNS);
  localparam logic [CELL_AW-1:0] LAST_CELL  = CELL_AW'(CELLS - 1);

  // Cell contents.
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0720;

  // Control characters.
  localparam logic [CHAR_W-1:0] CHAR_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_READ,
    ST_RDATA,
    ST_DONE
  } state_e;

  // What a cell write belongs to, and what follows a scroll.
  typedef enum logic [1:0] {
    OP_NL,
    OP_BS,
    OP_CHAR,
    OP_TAB
  } op_e;

endpackage

`default_nettype wire

FILE: sv/tcce_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 2000,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/text_console_character_engine.sv
// ----------------------------------------------------------------------------
// Text console character engine
// Character screen with cursor, newline, return, backspace, tab and scrolling.
// A scroll or a clear moves one cell per cycle through the single port pair
// of the screen RAM. One item at a time.
// After reset the RAM is blanked before the first item.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_character_engine (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input items
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [tcce_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [tcce_pkg::CHAR_W-1:0]    char_code_i,
  input  wire logic [tcce_pkg::ROW_W-1:0]     read_row_i,
  input  wire logic [tcce_pkg::COL_W-1:0]     read_col_i,
  // Result items
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [tcce_pkg::CURSOR_W-1:0]  cursor_index_o,
  output logic      [tcce_pkg::ROW_W-1:0]     cursor_row_o,
  output logic      [tcce_pkg::COL_W-1:0]     cursor_col_o,
  output logic      [tcce_pkg::CELL_W-1:0]    cell_data_o,
  // Configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tcce_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [tcce_pkg::PDATA_W-1:0]   pwdata,
  output logic      [tcce_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready
);

  import tcce_pkg::*;

  `include "text_console_character_engine_assert.svh"

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [KIND_W-1:0]    kind_q, kind_d;
  logic [CHAR_W-1:0]    code_q, code_d;
  logic [ROW_W-1:0]     rr_q, rr_d;
  logic [COL_W-1:0]     rc_q, rc_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [CURSOR_W-1:0]  hw_q, hw_d;
  logic [COLOR_W-1:0]   color_q;
  logic [CELL_AW-1:0]   ptr_q, ptr_d;
  logic [TAB_W-1:0]     tab_q, tab_d;
  logic [CELL_W-1:0]    data_q, data_d;
  logic                 out_valid_q, out_valid_d;
  logic [CURSOR_W-1:0]  out_index_q, out_index_d;
  logic [ROW_W-1:0]     out_row_q, out_row_d;
  logic [COL_W-1:0]     out_col_q, out_col_d;
  logic [CELL_W-1:0]    out_data_q, out_data_d;

  logic                 mem_we;
  logic [CELL_AW-1:0]   mem_waddr;
  logic [CELL_W-1:0]    mem_wdata;
  logic [CELL_AW-1:0]   mem_raddr;
  logic [CELL_W-1:0]    mem_rdata;

  logic [ROW_W-1:0]     mul_row;
  logic [COL_W-1:0]     mul_col;
  logic [CELL_AW-1:0]   mul_idx;
  logic                 wrap_pending;
  logic                 color_we;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  assign pready   = 1'b1;
  assign color_we = psel && penable && pwrite && (paddr == REG_TEXT_COLOR);
  assign prdata   = (paddr == REG_TEXT_COLOR) ? PDATA_W'(color_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= COLOR_RESET;
    end else if (color_we) begin
      color_q <= pwdata[COLOR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Screen store and the shared cell index unit
  // ---------------------------------------------------------------------------
  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // One row times COLUMNS plus column, shared by cell reads and cell writes.
  assign mul_row = (state_q == ST_READ) ? rr_q : row_q;
  assign mul_col = (state_q == ST_READ) ? rc_q : col_q;
  assign mul_idx = CELL_AW'(CELL_AW'(mul_row) * COLS_A + CELL_AW'(mul_col));

  assign wrap_pending = (col_q > COL_LAST);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      op_q        <= OP_NL;
      kind_q      <= KIND_PUT;
      row_q       <= '0;
      col_q       <= '0;
      hw_q        <= '0;
      ptr_q       <= '0;
      tab_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      kind_q      <= kind_d;
      row_q       <= row_d;
      col_q       <= col_d;
      hw_q        <= hw_d;
      ptr_q       <= ptr_d;
      tab_q       <= tab_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q      <= code_d;
    rr_q        <= rr_d;
    rc_q        <= rc_d;
    data_q      <= data_d;
    out_index_q <= out_index_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_data_q  <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    kind_d      = kind_q;
    code_d      = code_q;
    rr_d        = rr_q;
    rc_d        = rc_q;
    row_d       = row_q;
    col_d       = col_q;
    hw_d        = hw_q;
    ptr_d       = ptr_q;
    tab_d       = tab_q;
    data_d      = data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_index_d = out_index_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_data_d  = out_data_q;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = CLEAR_CELL;
    mem_raddr   = CELL_AW'(ptr_q + COLS_A);

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
        if (ptr_q == LAST_CELL) begin
          ptr_d = '0;
          if (state_q == ST_INIT) begin
            state_d = ST_IDLE;
          end else begin
            row_d   = '0;
            col_d   = '0;
            state_d = ST_DONE;
          end
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d  = kind_i;
          code_d  = char_code_i;
          rr_d    = read_row_i;
          rc_d    = read_col_i;
          data_d  = '0;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_d = ST_DONE;
        case (kind_q)
          KIND_PUT: begin
            case (code_q)
              CHAR_NL: begin
                op_d  = OP_NL;
                col_d = '0;
                if (row_q < ROW_LAST) begin
                  row_d = row_q + 1'b1;
                end else begin
                  ptr_d   = '0;
                  state_d = ST_SCROLL;
                end
              end
              CHAR_CR: begin
                col_d = '0;
              end
              CHAR_BS: begin
                // Backspace at the home position leaves everything as it is.
                if (row_q != '0 || col_q != '0) begin
                  op_d    = OP_BS;
                  state_d = ST_WRITE;
                  if (col_q == '0) begin
                    row_d = row_q - 1'b1;
                    col_d = COL_LAST;
                  end else begin
                    col_d = col_q - 1'b1;
                  end
                end
              end
              default: begin
                op_d    = (code_q == CHAR_TAB) ? OP_TAB : OP_CHAR;
                state_d = ST_WRITE;
                // After a wrap the column is zero, so a tab pads four cells.
                tab_d   = wrap_pending ? TAB_W'(4) : TAB_W'(TAB_W'(4) - {1'b0, col_q[1:0]});
                if (wrap_pending) begin
                  col_d = '0;
                  if (row_q < ROW_LAST) begin
                    row_d = row_q + 1'b1;
                  end else begin
                    ptr_d   = '0;
                    state_d = ST_SCROLL;
                  end
                end
              end
            endcase
          end
          KIND_READ: begin
            if (rr_q <= ROW_LAST && rc_q <= COL_LAST) begin
              state_d = ST_READ;
            end
          end
          KIND_CLEAR: begin
            ptr_d   = '0;
            state_d = ST_CLEAR;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = mul_idx;
        mem_wdata = {color_q, (op_q == OP_CHAR) ? code_q : BLANK_CHAR};
        hw_d      = CURSOR_W'(mul_idx);
        state_d   = ST_DONE;
        case (op_q)
          OP_CHAR: begin
            col_d = col_q + 1'b1;
          end
          OP_TAB: begin
            col_d = col_q + 1'b1;
            tab_d = tab_q - 1'b1;
            if (tab_q != TAB_W'(1) && col_q != COL_LAST) begin
              state_d = ST_WRITE;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      // Each cycle reads the cell one row below and writes the cell read
      // in the cycle before, so the whole copy streams at one cell a cycle.
      ST_SCROLL: begin
        row_d = ROW_LAST;
        if (ptr_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_q - 1'b1;
          mem_wdata = mem_rdata;
        end
        if (ptr_q == SCROLL_END) begin
          state_d = ST_BLANK;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = {color_q, BLANK_CHAR};
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == LAST_CELL) begin
          ptr_d   = '0;
          state_d = (op_q == OP_NL) ? ST_DONE : ST_WRITE;
        end
      end

      ST_READ: begin
        mem_raddr = mul_idx;
        state_d   = ST_RDATA;
      end

      ST_RDATA: begin
        data_d  = mem_rdata;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_index_d = hw_q;
          out_row_d   = row_q;
          out_col_d   = col_q;
          out_data_d  = data_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign cursor_index_o = out_index_q;
  assign cursor_row_o   = out_row_q;
  assign cursor_col_o   = out_col_q;
  assign cell_data_o    = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TCCE_ASSERT_NOW(a_cursor_bounds, clk_i, rst_ni, 1'b1, (row_q <= ROW_LAST) && (col_q <= COL_W'(COLUMNS)), "cursor row or column out of range")
  `TCCE_ASSERT_NOW(a_write_states, clk_i, rst_ni, mem_we, (state_q == ST_WRITE) || (state_q == ST_SCROLL) || (state_q == ST_BLANK) || (state_q == ST_CLEAR) || (state_q == ST_INIT), "screen written outside a write state")
  `TCCE_ASSERT_NOW(a_write_in_row, clk_i, rst_ni, state_q == ST_WRITE, col_q <= COL_LAST, "cell write with a wrap pending")
  `TCCE_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o && (state_q == ST_DECODE), "item accepted while busy")
  `TCCE_ASSERT_NOW(a_tab_count, clk_i, rst_ni, (state_q == ST_WRITE) && (op_q == OP_TAB), tab_q != '0, "tab write with no blanks left")

endmodule

`default_nettype wire

FILE: tb/console_status_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Console status checker
// Watches the item, result and configuration traffic of the text console
// engine. It keeps its own screen, cursor and attribute, predicts the status
// that each accepted item must return, and compares results in order.
// ----------------------------------------------------------------------------
module console_status_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Item channel
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [tcce_pkg::KIND_W-1:0]     kind_i,
  input  logic [tcce_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tcce_pkg::ROW_W-1:0]      read_row_i,
  input  logic [tcce_pkg::COL_W-1:0]      read_col_i,
  // Result channel
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [tcce_pkg::CURSOR_W-1:0]   cursor_index_i,
  input  logic [tcce_pkg::ROW_W-1:0]      cursor_row_i,
  input  logic [tcce_pkg::COL_W-1:0]      cursor_col_i,
  input  logic [tcce_pkg::CELL_W-1:0]     cell_data_i,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcce_pkg::PADDR_W-1:0]    paddr,
  input  logic [tcce_pkg::PDATA_W-1:0]    pwdata,
  input  logic                            pready,
  // Totals
  output int                              mismatches_o,
  output int                              outstanding_o,
  output int                              checked_o,
  output int                              scrolls_o
);

  import tcce_pkg::*;

  localparam int unsigned TAB_STOP  = 4;
  localparam int unsigned LOG_LIMIT = 50;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_index;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [CELL_W-1:0]   cell_word;
  } console_status_t;

  logic [CELL_W-1:0]   screen [CELLS];
  logic [ROW_W-1:0]    text_row;
  logic [COL_W-1:0]    text_col;
  logic [CURSOR_W-1:0] cursor_at;
  logic [COLOR_W-1:0]  attr;
  console_status_t     predicted_status_q [$];
  console_status_t     oldest;

  // Writes at the current row and column; the hardware cursor follows it.
  function automatic void write_cell(input logic [CHAR_W-1:0] ch);
    int unsigned idx;
    if (text_col >= COLUMNS || text_row >= ROWS) return;
    idx = text_row * COLUMNS + text_col;
    screen[idx] = {attr, ch};
    cursor_at = CURSOR_W'(idx);
  endfunction

  function automatic void line_feed();
    if (text_row < ROW_LAST) begin
      text_row = text_row + 1'b1;
    end else begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {attr, BLANK_CHAR};
      scrolls_o++;
    end
    text_col = '0;
  endfunction

  function automatic console_status_t compute_console_status(
      input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] code,
      input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
    console_status_t s;
    int unsigned pad;
    s.cell_word = '0;
    case (kind)
      KIND_PUT: begin
        case (code)
          CHAR_NL: line_feed();
          CHAR_CR: text_col = '0;
          CHAR_BS: begin
            // Nothing happens at home; from column 0 it backs onto the row above.
            if (text_col != 0 || text_row != 0) begin
              if (text_col == 0) begin
                text_row = text_row - 1'b1;
                text_col = COL_W'(COLUMNS);
              end
              text_col = text_col - 1'b1;
              write_cell(BLANK_CHAR);
            end
          end
          CHAR_TAB: begin
            if (text_col >= COLUMNS) line_feed();
            // Blanks stop at the right edge, which leaves a wrap pending.
            pad = TAB_STOP - (text_col % TAB_STOP);
            while (pad != 0 && text_col < COLUMNS) begin
              write_cell(BLANK_CHAR);
              text_col = text_col + 1'b1;
              pad--;
            end
          end
          default: begin
            if (text_col >= COLUMNS) line_feed();
            write_cell(code);
            text_col = text_col + 1'b1;
          end
        endcase
      end
      KIND_READ: begin
        if (rr < ROWS && rc < COLUMNS) s.cell_word = screen[rr * COLUMNS + rc];
      end
      KIND_CLEAR: begin
        foreach (screen[i]) screen[i] = CLEAR_CELL;
        text_row = '0;
        text_col = '0;
      end
      default: ;
    endcase
    s.cursor_index = cursor_at;
    s.row = text_row;
    s.col = text_col;
    return s;
  endfunction

  task automatic flag_error(input string what);
    if (mismatches_o < LOG_LIMIT) begin
      $display("console_status_checker: result %0d: %s", checked_o, what);
    end
    mismatches_o++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) flag_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (screen[i]) screen[i] = CLEAR_CELL;
      text_row = '0;
      text_col = '0;
      cursor_at = '0;
      attr = COLOR_RESET;
      predicted_status_q.delete();
      mismatches_o = 0;
      outstanding_o = 0;
      checked_o = 0;
      scrolls_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_TEXT_COLOR) begin
        attr = pwdata[COLOR_W-1:0];
      end
      if (in_valid_i && in_ready_i) begin
        predicted_status_q.push_back(
          compute_console_status(kind_i, char_code_i, read_row_i, read_col_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_status_q.size() == 0) begin
          flag_error("result arrived with no item waiting for it");
        end else begin
          oldest = predicted_status_q.pop_front();
          check_field("cursor_index", cursor_index_i, oldest.cursor_index);
          check_field("cursor_row", cursor_row_i, oldest.row);
          check_field("cursor_col", cursor_col_i, oldest.col);
          check_field("cell_data", cell_data_i, oldest.cell_word);
        end
        checked_o++;
      end
      outstanding_o = predicted_status_q.size();
    end
  end

endmodule

FILE: tb/tb_text_console_character_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console character engine testbench
// Drives characters, cell reads, clears and the spare kind through the item
// channel under random idling on both sides, changes the text attribute
// between phases, and leaves all checking to the console status checker.
// ----------------------------------------------------------------------------
module tb_text_console_character_engine;

  import tcce_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;
  localparam int unsigned       QUIET_LIMIT = 12000;
  localparam int unsigned       BURST_MAX   = 13;

  typedef enum int {MIX_TEXT, LONG_LINES, BOTTOM_SCROLL} traffic_e;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [KIND_W-1:0]     kind_i         = '0;
  logic [CHAR_W-1:0]     char_code_i    = '0;
  logic [ROW_W-1:0]      read_row_i     = '0;
  logic [COL_W-1:0]      read_col_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [CURSOR_W-1:0]   cursor_index_o;
  logic [ROW_W-1:0]      cursor_row_o;
  logic [COL_W-1:0]      cursor_col_o;
  logic [CELL_W-1:0]     cell_data_o;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [PADDR_W-1:0]    paddr          = '0;
  logic [PDATA_W-1:0]    pwdata         = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  int                    gap_pct        = 0;
  int                    stall_pct      = 0;
  int                    n_chars        = 0;
  int                    n_reads        = 0;
  int                    n_clears       = 0;
  int                    n_spare        = 0;
  int                    n_colors       = 0;
  int unsigned           quiet_cycles   = 0;
  logic [ROW_W-1:0]      last_row       = '0;
  int                    mismatches;
  int                    outstanding;
  int                    checked;
  int                    scrolls;

  text_console_character_engine dut (.*);

  console_status_checker status_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .kind_i         (kind_i),
    .char_code_i    (char_code_i),
    .read_row_i     (read_row_i),
    .read_col_i     (read_col_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_index_i (cursor_index_o),
    .cursor_row_i   (cursor_row_o),
    .cursor_col_i   (cursor_col_o),
    .cell_data_i    (cell_data_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .checked_o      (checked),
    .scrolls_o      (scrolls)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // A scroll or clear keeps both channels quiet.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable && pwrite && pready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb_text_console_character_engine: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    if (out_valid_o && out_ready_i) last_row <= cursor_row_o;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, BURST_MAX)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic offer(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] c,
                       input logic [ROW_W-1:0] r, input logic [COL_W-1:0] col);
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    char_code_i <= c;
    read_row_i  <= r;
    read_col_i  <= col;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    case (k)
      KIND_PUT:   n_chars++;
      KIND_READ:  n_reads++;
      KIND_CLEAR: n_clears++;
      default:    n_spare++;
    endcase
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic set_text_color(input logic [COLOR_W-1:0] color);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_TEXT_COLOR;
    pwdata  <= PDATA_W'(color);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_colors++;
  endtask

  task automatic pick_item(input traffic_e mode, output logic [KIND_W-1:0] k,
                           output logic [CHAR_W-1:0] c, output logic [ROW_W-1:0] r,
                           output logic [COL_W-1:0] col);
    int unsigned roll;
    int unsigned aim;
    int unsigned p_read, p_nl, p_cr, p_bs, p_tab, p_clear, p_spare;
    case (mode)
      LONG_LINES: begin
        p_read = 8;  p_nl = 1;  p_cr = 1; p_bs = 4; p_tab = 12; p_clear = 1; p_spare = 1;
      end
      BOTTOM_SCROLL: begin
        p_read = 20; p_nl = 30; p_cr = 3; p_bs = 5; p_tab = 5;  p_clear = 1; p_spare = 1;
      end
      default: begin
        p_read = 15; p_nl = 8;  p_cr = 4; p_bs = 6; p_tab = 6;  p_clear = 2; p_spare = 2;
      end
    endcase
    roll = $urandom_range(0, 99);
    k = KIND_PUT;
    c = CHAR_W'($urandom);
    r = ROW_W'($urandom);
    col = COL_W'($urandom);
    if (roll < p_read) begin
      k = KIND_READ;
      aim = $urandom_range(0, 99);
      if (aim < 50) begin
        // Recent writes sit on the cursor row or just above it.
        r = (last_row != 0 && aim < 15) ? last_row - 1'b1 : last_row;
        col = COL_W'($urandom_range(0, COLUMNS - 1));
      end else if (aim < 85) begin
        r = ROW_W'($urandom_range(0, ROWS - 1));
        col = COL_W'($urandom_range(0, COLUMNS - 1));
      end
    end else if (roll < p_read + p_nl) begin
      c = CHAR_NL;
    end else if (roll < p_read + p_nl + p_cr) begin
      c = CHAR_CR;
    end else if (roll < p_read + p_nl + p_cr + p_bs) begin
      c = CHAR_BS;
    end else if (roll < p_read + p_nl + p_cr + p_bs + p_tab) begin
      c = CHAR_TAB;
    end else if (roll < p_read + p_nl + p_cr + p_bs + p_tab + p_clear) begin
      k = KIND_CLEAR;
    end else if (roll < p_read + p_nl + p_cr + p_bs + p_tab + p_clear + p_spare) begin
      k = KIND_SPARE;
    end
  endtask

  task automatic run_phase(input traffic_e mode, input int count);
    logic [KIND_W-1:0] k;
    logic [CHAR_W-1:0] c;
    logic [ROW_W-1:0]  r;
    logic [COL_W-1:0]  col;
    repeat (count) begin
      if ($urandom_range(0, 99) < gap_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, BURST_MAX)) @(negedge clk_i);
      end
      pick_item(mode, k, c, r, col);
      offer(k, c, r, col);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed item sequence with the reset attribute.
    offer(KIND_READ, 8'h00, 5'd0, 7'd0);
    offer(KIND_PUT, CHAR_BS, '1, '1);
    offer(KIND_PUT, 8'h41, '0, '0);
    offer(KIND_PUT, 8'h00, '0, '0);
    offer(KIND_PUT, 8'hFF, '1, '1);
    offer(KIND_PUT, CHAR_TAB, '0, '0);
    offer(KIND_PUT, CHAR_CR, '1, '1);
    offer(KIND_READ, 8'h00, 5'd0, 7'd1);
    offer(KIND_PUT, CHAR_NL, '0, '0);
    offer(KIND_PUT, CHAR_BS, '0, '0);
    offer(KIND_PUT, 8'h5A, '0, '0);
    offer(KIND_PUT, CHAR_TAB, '1, '1);
    offer(KIND_PUT, 8'h7E, '0, '0);
    offer(KIND_READ, 8'h00, 5'd0, 7'd79);
    offer(KIND_READ, 8'hFF, '1, '1);
    offer(KIND_READ, 8'h00, 5'd24, 7'd80);
    offer(KIND_READ, 8'h00, 5'd25, 7'd0);
    offer(KIND_SPARE, 8'hFF, '1, '1);
    offer(KIND_READ, 8'hFF, 5'd24, 7'd79);
    offer(KIND_CLEAR, 8'hFF, '1, '1);
    offer(KIND_READ, 8'h00, 5'd1, 7'd0);
    offer(KIND_PUT, 8'h71, '0, '0);
    offer(KIND_PUT, CHAR_CR, '0, '0);

    // Random phases; the attribute only changes once every result is back.
    wait_idle();
    set_text_color(8'hFF);
    gap_pct = 20;
    stall_pct = 20;
    run_phase(MIX_TEXT, 120);

    wait_idle();
    set_text_color(8'h00);
    gap_pct = 10;
    stall_pct = 5;
    run_phase(LONG_LINES, 110);

    wait_idle();
    set_text_color(COLOR_W'($urandom));
    gap_pct = 0;
    stall_pct = 0;
    run_phase(BOTTOM_SCROLL, 90);

    wait_idle();
    set_text_color(COLOR_W'($urandom));
    gap_pct = 25;
    stall_pct = 25;
    run_phase(LONG_LINES, 60);

    wait_idle();
    set_text_color(COLOR_W'($urandom));
    gap_pct = 0;
    stall_pct = 0;
    run_phase(MIX_TEXT, 100);

    wait_idle();
    repeat (16) @(negedge clk_i);
    $display("Sent %0d items: %0d put, %0d read, %0d clear, %0d spare kind.",
             n_chars + n_reads + n_clears + n_spare, n_chars, n_reads, n_clears, n_spare);
    $display("Compared %0d results across %0d attribute settings with %0d scrolls.",
             checked, n_colors, scrolls);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_text_console_character_engine: clean");
    end else begin
      $display("tb_text_console_character_engine: errors");
    end
    $finish;
  end

endmodule
